>>> rtl/assert_macros.svh
// Assertion helpers shared by cmf_front, cmf_queue and cmf_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Condition must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant check failed");

`endif

>>> rtl/cmf_pkg.sv
package cmf_pkg;

   localparam logic [7:0]  PREAMBLE       = 8'h73;
   localparam logic [7:0]  PAD_BYTE       = 8'h00;
   localparam logic [15:0] CRC16_POLY     = 16'h1021;
   localparam int          HDR_DATA_BYTES = 9;
   localparam int          HDR_DATA_W     = HDR_DATA_BYTES * 8;
   localparam int          HDR_CNT_W      = $clog2(HDR_DATA_BYTES + 1);
   localparam int          CRC4_PERIOD    = 15;
   localparam int          CRC4_SHIFT     = 8;

   localparam logic KIND_HEADER  = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   // x^n mod (x^4 + x + 1), n = 0..14
   localparam logic [3:0] CRC4_POW [CRC4_PERIOD] = '{
      4'h1, 4'h2, 4'h4, 4'h8, 4'h3, 4'h6, 4'hC, 4'hB,
      4'h5, 4'hA, 4'h7, 4'hE, 4'hF, 4'hD, 4'h9
   };

   typedef struct packed {
      logic                  is_header;
      logic                  last;
      logic [HDR_DATA_W-1:0] data;
   } entry_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC16_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

   // 20 header bits followed by four zeros, init 0: h(x) * x^8 mod g(x)
   function automatic logic [3:0] crc4_header(input logic [19:0] h);
      logic [3:0] r;
      r = '0;
      for (int j = 0; j < 20; j++) begin
         if (h[j]) begin
            r = r ^ CRC4_POW[(j + CRC4_SHIFT) % CRC4_PERIOD];
         end
      end
      return r;
   endfunction

endpackage

>>> rtl/cmf_front.sv
`include "assert_macros.svh"

module cmf_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_kind,
   input  logic [6:0]         req_message_type,
   input  logic [3:0]         req_message_subtype,
   input  logic [9:0]         req_payload_length,
   input  logic [31:0]        req_time_tag,
   input  logic [7:0]         req_payload_byte,
   input  logic               q_full,
   output logic               q_push,
   output cmf_pkg::entry_type q_push_entry
);
   import cmf_pkg::*;

   logic       in_frame_ff, in_frame_in;
   logic [9:0] bytes_left_ff, bytes_left_in;
   logic       accept;
   logic [19:0] h20;
   logic [3:0]  hcrc;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   assign h20  = {req_message_type, req_payload_length, 1'b0, 2'b01};
   assign hcrc = crc4_header(h20);

   always_comb begin
      in_frame_in   = in_frame_ff;
      bytes_left_in = bytes_left_ff;
      q_push        = 1'b0;
      q_push_entry.is_header = 1'b1;
      q_push_entry.last      = 1'b0;
      q_push_entry.data      = {h20, hcrc, req_message_subtype, 1'b1, req_time_tag, 11'b0};
      if (accept) begin
         if (req_kind == KIND_HEADER) begin
            q_push              = 1'b1;
            q_push_entry.last   = (req_payload_length == 10'd0);
            in_frame_in         = (req_payload_length != 10'd0);
            bytes_left_in       = req_payload_length;
         end else if (in_frame_ff) begin
            q_push                 = 1'b1;
            q_push_entry.is_header = 1'b0;
            q_push_entry.last      = (bytes_left_ff == 10'd1);
            q_push_entry.data      = {{(HDR_DATA_W-8){1'b0}}, req_payload_byte};
            bytes_left_in          = bytes_left_ff - 10'd1;
            in_frame_in            = (bytes_left_ff != 10'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         bytes_left_ff <= '0;
      end else begin
         in_frame_ff   <= in_frame_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

   `ASSERT_ALWAYS(a_frame_count, clock, reset, in_frame_ff == (bytes_left_ff != 10'd0))

endmodule

>>> rtl/cmf_queue.sv
`include "assert_macros.svh"

module cmf_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  cmf_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output cmf_pkg::entry_type head,
   output logic               empty
);
   import cmf_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `ASSERT_IMP(a_no_overflow, clock, reset, push, !full)
   `ASSERT_IMP(a_no_underflow, clock, reset, pop, !empty)

endmodule

>>> rtl/cmf_back.sv
`include "assert_macros.svh"

module cmf_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  cmf_pkg::entry_type q_head,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_frame_end
);
   import cmf_pkg::*;

   typedef enum logic [4:0] {
      ST_DATA   = 5'b00001,
      ST_HDR    = 5'b00010,
      ST_CRC_HI = 5'b00100,
      ST_CRC_LO = 5'b01000,
      ST_PAD    = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [HDR_DATA_W-1:0] hdr_ff, hdr_in;
   logic [HDR_CNT_W-1:0]  hdr_cnt_ff, hdr_cnt_in;
   logic                  last_ff, last_in;
   logic [15:0]           crc_ff, crc_in;
   logic                  odd_ff, odd_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            byte_ff, byte_in;
   logic                  end_ff, end_in;
   logic                  advance;
   logic                  emit;

   assign advance = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in   = state_ff;
      hdr_in     = hdr_ff;
      hdr_cnt_in = hdr_cnt_ff;
      last_in    = last_ff;
      crc_in     = crc_ff;
      odd_in     = odd_ff;
      q_pop      = 1'b0;
      emit       = 1'b0;
      byte_in    = byte_ff;
      end_in     = 1'b0;
      if (advance) begin
         case (state_ff)
            ST_DATA: begin
               if (!q_empty) begin
                  q_pop = 1'b1;
                  emit  = 1'b1;
                  if (q_head.is_header) begin
                     byte_in    = PREAMBLE;
                     crc_in     = '0;
                     odd_in     = 1'b1;
                     hdr_in     = q_head.data;
                     hdr_cnt_in = HDR_CNT_W'(HDR_DATA_BYTES);
                     last_in    = q_head.last;
                     state_in   = ST_HDR;
                  end else begin
                     byte_in = q_head.data[7:0];
                     crc_in  = crc16_byte(crc_ff, q_head.data[7:0]);
                     odd_in  = !odd_ff;
                     if (q_head.last) begin
                        state_in = ST_CRC_HI;
                     end
                  end
               end
            end
            ST_HDR: begin
               emit       = 1'b1;
               byte_in    = hdr_ff[HDR_DATA_W-1 -: 8];
               hdr_in     = {hdr_ff[HDR_DATA_W-9:0], 8'h00};
               crc_in     = crc16_byte(crc_ff, hdr_ff[HDR_DATA_W-1 -: 8]);
               odd_in     = !odd_ff;
               hdr_cnt_in = hdr_cnt_ff - 1'b1;
               if (hdr_cnt_ff == HDR_CNT_W'(1)) begin
                  state_in = last_ff ? ST_CRC_HI : ST_DATA;
               end
            end
            ST_CRC_HI: begin
               emit     = 1'b1;
               byte_in  = crc_ff[15:8];
               odd_in   = !odd_ff;
               state_in = ST_CRC_LO;
            end
            ST_CRC_LO: begin
               emit    = 1'b1;
               byte_in = crc_ff[7:0];
               odd_in  = !odd_ff;
               // odd count so far means the frame closes even: no pad
               if (odd_ff) begin
                  end_in   = 1'b1;
                  state_in = ST_DATA;
               end else begin
                  state_in = ST_PAD;
               end
            end
            ST_PAD: begin
               emit     = 1'b1;
               byte_in  = PAD_BYTE;
               odd_in   = !odd_ff;
               end_in   = 1'b1;
               state_in = ST_DATA;
            end
            default: state_in = ST_DATA;
         endcase
      end
      rsp_valid_in = advance ? emit : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_DATA;
         hdr_cnt_ff   <= '0;
         last_ff      <= 1'b0;
         crc_ff       <= '0;
         odd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         last_ff      <= last_in;
         crc_ff       <= crc_in;
         odd_ff       <= odd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
      if (advance && emit) begin
         byte_ff <= byte_in;
         end_ff  <= end_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_frame_end = end_ff;

   `ASSERT_IMP(a_busy_has_output, clock, reset,
      (state_ff == ST_HDR) || (state_ff == ST_CRC_LO) || (state_ff == ST_PAD), rsp_valid_ff)
   `ASSERT_IMP(a_end_closes_frame, clock, reset, rsp_valid_ff && end_ff, state_ff == ST_DATA)

endmodule

>>> rtl/correction_message_framer.sv
// Correction message framer: builds transport frames byte by byte.
// Input (req_*): kind 0 starts a frame from the header fields, kind 1 carries
// one payload byte. Payload bytes outside a frame are taken and dropped.
// Output (rsp_*): one frame byte per transaction; rsp_frame_end marks the
// last byte (low CRC byte, or the zero pad when the frame length is odd).
// A header transaction yields 10 bytes (12 for zero payload length); the
// final payload byte yields 3 or 4 (byte, CRC high, CRC low, optional pad).
// Throughput: while rsp_ready is high, one output byte per cycle, set by the
// single output register in the emitter, and payload bytes stream at one per
// cycle. A 4-entry queue (QUEUE_DEPTH) between classifier and emitter absorbs
// header expansion. When rsp_ready is low the output byte holds, the emitter
// stalls, and req_ready drops once the queue fills. A header inside an open
// frame drops the unfinished frame without CRC and starts a new one.
// Reset (synchronous) empties the queue and clears frame and CRC state.
module correction_message_framer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [6:0]  req_message_type,
   input  logic [3:0]  req_message_subtype,
   input  logic [9:0]  req_payload_length,
   input  logic [31:0] req_time_tag,
   input  logic [7:0]  req_payload_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_frame_end
);
   import cmf_pkg::*;

   entry_type push_entry;
   entry_type head;
   logic      push;
   logic      pop;
   logic      full;
   logic      empty;

   cmf_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_message_type    (req_message_type),
      .req_message_subtype (req_message_subtype),
      .req_payload_length  (req_payload_length),
      .req_time_tag        (req_time_tag),
      .req_payload_byte    (req_payload_byte),
      .q_full              (full),
      .q_push              (push),
      .q_push_entry        (push_entry)
   );

   cmf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head       (head),
      .empty      (empty)
   );

   cmf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (empty),
      .q_head        (head),
      .q_pop         (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

>>> sim/frame_check_pkg.sv
`timescale 1ns / 1ps

package frame_check_pkg;
   import cmf_pkg::*;

   class frame_scoreboard;
      typedef struct {
         logic [7:0] data;
         logic       last;
      } frame_byte_type;

      frame_byte_type expected_bytes[$];
      bit          in_frame;
      bit [9:0]    bytes_left;
      bit [15:0]   running_crc;
      bit          odd_count;
      int          errors;
      int          bytes_checked;
      int          headers_seen;
      int          frames_closed;
      int          stray_dropped;

      function bit [15:0] crc16_next(bit [15:0] crc, bit [7:0] b);
         bit [15:0] c;
         c = crc ^ {b, 8'h00};
         repeat (8) begin
            if (c[15]) c = {c[14:0], 1'b0} ^ CRC16_POLY;
            else c = {c[14:0], 1'b0};
         end
         return c;
      endfunction

      // x^4+x+1, MSB first, zero init
      function bit [3:0] header_crc4(bit [23:0] bits);
         bit [3:0] c;
         bit       fb;
         c = '0;
         for (int i = 23; i >= 0; i--) begin
            fb = bits[i] ^ c[3];
            c = {c[2:0], 1'b0};
            if (fb) c ^= 4'h3;
         end
         return c;
      endfunction

      function void push_byte(bit [7:0] b, bit last, bit crc_it);
         frame_byte_type e;
         e.data = b;
         e.last = last;
         expected_bytes.insert(expected_bytes.size(), e);
         odd_count ^= 1'b1;
         if (crc_it) running_crc = crc16_next(running_crc, b);
      endfunction

      function void close_frame();
         bit [15:0] snap;
         bit        pad;
         snap = running_crc;
         push_byte(snap[15:8], 1'b0, 1'b0);
         pad = (odd_count == 1'b0);
         push_byte(snap[7:0], !pad, 1'b0);
         if (pad) push_byte(PAD_BYTE, 1'b1, 1'b0);
         in_frame = 1'b0;
         bytes_left = '0;
         frames_closed++;
      endfunction

      // Returns the number of frame bytes the transaction adds.
      function int note_request(logic kind, logic [6:0] mtype, logic [3:0] sub,
                                logic [9:0] len, logic [31:0] ttag, logic [7:0] pbyte);
         int        before_count;
         bit [19:0] h20;
         bit [23:0] top;
         bit [47:0] tail;
         before_count = expected_bytes.size();
         if (kind == KIND_HEADER) begin
            headers_seen++;
            h20 = {mtype, len, 1'b0, 2'b01};
            top = {h20, header_crc4({h20, 4'b0000})};
            tail = {sub, 1'b1, ttag, 11'b0};
            running_crc = '0;
            odd_count = 1'b0;
            push_byte(PREAMBLE, 1'b0, 1'b0);
            for (int i = 2; i >= 0; i--) push_byte(top[8*i +: 8], 1'b0, 1'b1);
            for (int i = 5; i >= 0; i--) push_byte(tail[8*i +: 8], 1'b0, 1'b1);
            if (len == 0) close_frame();
            else begin
               in_frame = 1'b1;
               bytes_left = len;
            end
         end else if (!in_frame) begin
            stray_dropped++;
         end else begin
            push_byte(pbyte, 1'b0, 1'b1);
            bytes_left = bytes_left - 1'b1;
            if (bytes_left == 0) close_frame();
         end
         return expected_bytes.size() - before_count;
      endfunction

      function void check_byte(logic [7:0] out_byte, logic frame_end);
         frame_byte_type e;
         bytes_checked++;
         if (expected_bytes.size() == 0) begin
            $error("unexpected byte: out_byte %02h frame_end %0b", out_byte, frame_end);
            errors++;
            return;
         end
         e = expected_bytes.pop_front();
         if (out_byte !== e.data) begin
            $error("out_byte mismatch: expected %02h, actual %02h", e.data, out_byte);
            errors++;
         end
         if (frame_end !== e.last) begin
            $error("frame_end mismatch: expected %0b, actual %0b", e.last, frame_end);
            errors++;
         end
      endfunction
   endclass

endpackage

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import cmf_pkg::*;
   import frame_check_pkg::*;

   localparam int RANDOM_ITEMS = 380;
   localparam int CYCLE_LIMIT  = 300000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = KIND_PAYLOAD;
   logic [6:0]  req_message_type = '0;
   logic [3:0]  req_message_subtype = '0;
   logic [9:0]  req_payload_length = '0;
   logic [31:0] req_time_tag = '0;
   logic [7:0]  req_payload_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_frame_end;

   frame_scoreboard frames = new;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_request = 1'b0;
   int items_counted = 0;
   int cycle_count = 0;

   correction_message_framer dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_message_type    (req_message_type),
      .req_message_subtype (req_message_subtype),
      .req_payload_length  (req_payload_length),
      .req_time_tag        (req_time_tag),
      .req_payload_byte    (req_payload_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_frame_end       (rsp_frame_end)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $error("timeout after %0d cycles, %0d bytes outstanding", cycle_count,
                frames.expected_bytes.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver: random stalls plus a long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) frames.check_byte(rsp_out_byte, rsp_frame_end);
         if (hold_request) begin
            hold_left = 250;
            hold_request <= 1'b0;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic send_item(input logic kind, input logic [6:0] mtype, input logic [3:0] sub,
                            input logic [9:0] len, input logic [31:0] ttag,
                            input logic [7:0] pbyte);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_kind            <= kind;
      req_message_type    <= mtype;
      req_message_subtype <= sub;
      req_payload_length  <= len;
      req_time_tag        <= ttag;
      req_payload_byte    <= pbyte;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (frames.note_request(kind, mtype, sub, len, ttag, pbyte) > 0) items_counted++;
   endtask

   task automatic send_header(input logic [6:0] mtype, input logic [3:0] sub,
                              input logic [9:0] len, input logic [31:0] ttag);
      send_item(KIND_HEADER, mtype, sub, len, ttag, 8'($urandom_range(255)));
   endtask

   task automatic send_payload(input logic [7:0] pbyte);
      send_item(KIND_PAYLOAD, 7'($urandom_range(127)), 4'($urandom_range(15)),
                10'($urandom_range(1023)), $urandom(), pbyte);
   endtask

   task automatic send_frame(input int len, input int count);
      send_header(7'($urandom_range(127)), 4'($urandom_range(15)), 10'(len), $urandom());
      repeat (count) send_payload(8'($urandom_range(255)));
   endtask

   task automatic random_traffic();
      int pick;
      int roll;
      int len;
      pick = $urandom_range(99);
      if (pick < 78) begin
         roll = $urandom_range(99);
         if (roll < 10) len = 0;
         else if (roll < 85) len = $urandom_range(10, 1);
         else len = $urandom_range(40, 11);
         send_frame(len, len);
      end else if (pick < 90) begin
         // left open for a later header to abandon, unless later payload bytes complete it
         len = $urandom_range(1023, 2);
         send_frame(len, $urandom_range((len - 1 > 12) ? 12 : len - 1, 0));
      end else begin
         repeat ($urandom_range(3, 1)) send_payload(8'($urandom_range(255)));
      end
   endtask

   initial begin
      int target;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_payload(8'hFF);
      send_header(7'h00, 4'h0, 10'd0, 32'h0000_0000);
      send_header(7'h7F, 4'hF, 10'd0, 32'hFFFF_FFFF);
      send_header(7'h55, 4'hA, 10'd1, 32'h1234_5678);
      send_payload(8'hFF);
      send_header(7'h2A, 4'h5, 10'd2, 32'h8000_0001);
      send_payload(8'h00);
      send_payload(8'hA5);
      send_header(7'h01, 4'h1, 10'd1023, $urandom());
      repeat (3) send_payload(8'($urandom_range(255)));
      send_header(7'h40, 4'h8, 10'd1, $urandom());
      send_payload(8'h5A);
      send_payload(8'h00);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
            default: begin send_idle_pct = 22; recv_stall_pct = 22; end
         endcase
         if (phase == 0) begin
            hold_request <= 1'b1;
            send_frame(40, 40);
         end
         target = items_counted + RANDOM_ITEMS / 4;
         while (items_counted < target) random_traffic();
      end
      req_valid <= 1'b0;

      while (frames.expected_bytes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Covered %0d transactions: %0d headers, %0d frames closed, %0d stray bytes dropped",
               items_counted + frames.stray_dropped, frames.headers_seen, frames.frames_closed,
               frames.stray_dropped);
      $display("Checked %0d frame bytes under four idle/stall mixes and one long output hold-off",
               frames.bytes_checked);
      if (frames.errors == 0 && frames.expected_bytes.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/cmf_pkg.sv
rtl/cmf_front.sv
rtl/cmf_queue.sv
rtl/cmf_back.sv
rtl/correction_message_framer.sv
sim/frame_check_pkg.sv
sim/tb_top.sv
